// File: hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median filter
// Defaults for the window depth and sample width, the register map and the
// flag bundle that each cell hands to its neighbours.
// ----------------------------------------------------------------------------
package swm_pkg;

	// default depth of the cell row and default sample width
	localparam int MAX_WINDOW_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	// window size register
	localparam int              WSIZE_W   = 5;
	localparam logic [WSIZE_W-1:0] WSIZE_RST = 5'd3;

	// register map: byte address bit 2 selects the register word
	localparam int   PADDR_W         = 3;
	localparam logic REG_WINDOW_SIZE = 1'b0;

	// ordering and deletion flags passed along the cell row
	typedef struct packed {
		logic le;     // cell is occupied and holds a value not above the new sample
		logic dseen;  // the cell being dropped lies at or below this place
	} swm_flag_t;

endpackage

// File: hw/rtl/swm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell: one place of the sorted window
// Holds one sample and its age (0 = newest). Per item it keeps its value,
// takes the new sample, or takes the value of its left or right neighbour,
// so that the row stays sorted with the new sample in and the oldest out.
// ----------------------------------------------------------------------------
module swm_cell
	import swm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int AGE_W       = 4
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          occ,
	input  logic                          del_en,
	input  logic [AGE_W-1:0]              del_age,
	input  logic                          del_before,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  swm_flag_t                     left_flag,
	input  logic signed [SAMPLE_BITS-1:0] left_val,
	input  logic [AGE_W-1:0]              left_age,
	input  swm_flag_t                     right_flag,
	input  logic signed [SAMPLE_BITS-1:0] right_val,
	input  logic [AGE_W-1:0]              right_age,
	output swm_flag_t                     flag,
	output logic                          del_lo,
	output logic signed [SAMPLE_BITS-1:0] val,
	output logic [AGE_W-1:0]              age,
	output logic signed [SAMPLE_BITS-1:0] post_val
);

	localparam logic [1:0] SEL_HOLD  = 2'd0;
	localparam logic [1:0] SEL_NEW   = 2'd1;
	localparam logic [1:0] SEL_LEFT  = 2'd2;
	localparam logic [1:0] SEL_RIGHT = 2'd3;

	logic signed [SAMPLE_BITS-1:0] val_q;
	logic [AGE_W-1:0]              age_q;
	logic                          drop;
	logic [1:0]                    sel;

	// compare against the new sample and spot the oldest entry
	assign flag.le    = occ && (val_q <= sample);
	assign drop       = del_en && occ && (age_q == del_age);
	assign flag.dseen = left_flag.dseen | drop;
	assign del_lo     = drop & flag.le;

	// value at this place once the new sample is in, before the drop
	assign post_val = flag.le ? val_q : (left_flag.le ? sample : left_val);

	// choose the source of the next value
	always_comb begin
		sel = SEL_HOLD;
		if (del_before) begin
			if (flag.le && !right_flag.le) begin
				sel = SEL_NEW;
			end else if (flag.dseen && right_flag.le) begin
				sel = SEL_RIGHT;
			end
		end else begin
			if (!flag.le && left_flag.le) begin
				sel = SEL_NEW;
			end else if (!left_flag.le && !left_flag.dseen) begin
				sel = SEL_LEFT;
			end
		end
	end

	// advance value and age
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (sel)
				SEL_NEW: begin
					val_q <= sample;
					age_q <= '0;
				end
				SEL_LEFT: begin
					val_q <= left_val;
					age_q <= left_age + 1'b1;
				end
				SEL_RIGHT: begin
					val_q <= right_val;
					age_q <= right_age + 1'b1;
				end
				default: begin
					age_q <= age_q + 1'b1;
				end
			endcase
		end
	end

	assign val = val_q;
	assign age = age_q;

endmodule

// File: hw/rtl/sliding_window_median_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_core: running median over a sliding window
// Samples enter on the s_axis channel; twice the window median leaves on the
// m_axis channel. The window size is set through the APB register at 0x0.
//
// One item is taken per clock while s_axis_tready is high. The row of
// MAX_WINDOW cells inserts the new sample, gives the median and drops the
// oldest sample in the same cycle, so the rate is one item per cycle, set by
// that row update. A result is in the output register in the cycle after its item.
// No result is given until the window holds window_size samples; after that
// every item gives one. tlast on an input item empties the window after it.
// Writing window_size (0 reads as 1, above MAX_WINDOW as MAX_WINDOW) also
// empties the window. Reset empties the window and sets window_size to 3;
// there is no clearing pass, the block takes items right after reset.
// When the receiver stalls with a result held, s_axis_tready drops until the
// result is taken; an item that gives no result still needs that slot free.
// ----------------------------------------------------------------------------
module sliding_window_median_core
	import swm_pkg::*;
#(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_BITS + 1 + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// input items
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [IN_W-1:0]    s_axis_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
	input  logic               s_axis_tlast,   // last_sample
	// result items
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [OUT_W-1:0]   m_axis_tdata,   // [SAMPLE_BITS:0] median_times_two, rest zero
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);

	logic [WSIZE_W-1:0]            wsize_q;
	logic [CNT_W-1:0]              fill_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS:0]   out_med_q;

	logic                          cfg_wr;
	logic                          accept;
	logic [CNT_W-1:0]              k_eff;
	logic                          emit;
	logic                          ins_en;
	logic                          del_en;
	logic [AGE_W-1:0]              del_age;
	logic                          del_before;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [AGE_W-1:0]              mid_hi;
	logic [AGE_W-1:0]              mid_lo;
	logic signed [SAMPLE_BITS-1:0] med_hi;
	logic signed [SAMPLE_BITS-1:0] med_lo;
	logic signed [SAMPLE_BITS:0]   median;
	logic [OUT_W-1:0]              out_word;

	logic signed [SAMPLE_BITS-1:0] cell_val  [MAX_WINDOW];
	logic [AGE_W-1:0]              cell_age  [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] cell_post [MAX_WINDOW];
	swm_flag_t                     cell_flag [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]         cell_dlo;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);
	assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? {{(32 - WSIZE_W){1'b0}}, wsize_q} : '0;

	// effective window: zero reads as one, saturate at the row depth
	always_comb begin
		if (wsize_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (32'(wsize_q) > MAX_WINDOW) begin
			k_eff = CNT_W'(MAX_WINDOW);
		end else begin
			k_eff = CNT_W'(wsize_q);
		end
	end

	// item control
	assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign emit          = ({1'b0, fill_q} + 1'b1) >= {1'b0, k_eff};
	assign ins_en        = !(emit && (fill_q == '0));
	assign del_en        = emit && (fill_q != '0);
	assign del_age       = AGE_W'(fill_q - 1'b1);
	assign del_before    = |cell_dlo;

	// row of cells
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		swm_flag_t                     lf;
		swm_flag_t                     rf;
		logic signed [SAMPLE_BITS-1:0] lv;
		logic signed [SAMPLE_BITS-1:0] rv;
		logic [AGE_W-1:0]              la;
		logic [AGE_W-1:0]              ra;

		if (i == 0) begin : g_lo
			assign lf = '{le: 1'b1, dseen: 1'b0};
			assign lv = cell_val[i];
			assign la = cell_age[i];
		end else begin : g_lm
			assign lf = cell_flag[i-1];
			assign lv = cell_val[i-1];
			assign la = cell_age[i-1];
		end
		if (i == MAX_WINDOW - 1) begin : g_hi
			assign rf = '{le: 1'b0, dseen: 1'b0};
			assign rv = cell_val[i];
			assign ra = cell_age[i];
		end else begin : g_hm
			assign rf = cell_flag[i+1];
			assign rv = cell_val[i+1];
			assign ra = cell_age[i+1];
		end

		swm_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.AGE_W      (AGE_W)
		) u_cell (
			.clk       (clk),
			.en        (accept && ins_en),
			.occ       (CNT_W'(i) < fill_q),
			.del_en    (del_en),
			.del_age   (del_age),
			.del_before(del_before),
			.sample    (sample),
			.left_flag (lf),
			.left_val  (lv),
			.left_age  (la),
			.right_flag(rf),
			.right_val (rv),
			.right_age (ra),
			.flag      (cell_flag[i]),
			.del_lo    (cell_dlo[i]),
			.val       (cell_val[i]),
			.age       (cell_age[i]),
			.post_val  (cell_post[i])
		);
	end

	// pick the middle entries of the window with the new sample in
	assign mid_hi = AGE_W'(k_eff >> 1);
	assign mid_lo = mid_hi - 1'b1;
	assign med_hi = cell_post[mid_hi];
	assign med_lo = cell_post[mid_lo];
	assign median = k_eff[0] ? {med_hi, 1'b0}
	                         : ({med_hi[SAMPLE_BITS-1], med_hi} + {med_lo[SAMPLE_BITS-1], med_lo});

	// window size register and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q <= WSIZE_RST;
			fill_q  <= '0;
		end else if (cfg_wr) begin
			wsize_q <= pwdata[WSIZE_W-1:0];
			fill_q  <= '0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				fill_q <= '0;
			end else if (!emit) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_med_q <= median;
		end
	end

	always_comb begin
		out_word                = '0;
		out_word[SAMPLE_BITS:0] = out_med_q;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_word;

	// the window never holds a full window between items
	a_fill_below_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < k_eff)
		else $error("fill count reached the window size");

	// an item marked last empties the window
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tlast && !cfg_wr) |=> (fill_q == '0))
		else $error("window not emptied after last item");

	// a window size write empties the window
	a_cfg_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (fill_q == '0))
		else $error("window not emptied after size write");

	// a result is only loaded from an item that fills the window
	a_emit_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |-> ({1'b0, fill_q} + 1'b1 == {1'b0, k_eff}))
		else $error("result from a window that is not full");

endmodule
